### rtl/assert_macros.svh
// shared assertion macros, checks run on clk_i with reset rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/rhsv_pkg.sv
package rhsv_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned ChW   = 8;
  localparam int unsigned SecW  = 11;  // hue numerator and 6*d
  localparam int unsigned ModeW = 2;
  localparam int unsigned AmtW  = 24;
  localparam int unsigned IdxW  = 1;

  localparam logic [ModeW-1:0] MODE_HUE = 2'd0;
  localparam logic [ModeW-1:0] MODE_SAT = 2'd1;
  localparam logic [ModeW-1:0] MODE_VAL = 2'd2;

  localparam logic [IdxW-1:0] REG_MODE   = 1'b0;
  localparam logic [IdxW-1:0] REG_AMOUNT = 1'b1;

  typedef struct packed {
    logic [ChW-1:0]  mx;
    logic [ChW-1:0]  d;
    logic [SecW-1:0] n;
    logic            hue_zero;
    logic            sat_zero;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage

### rtl/rhsv_front.sv
module rhsv_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [rhsv_pkg::ChW-1:0] red_i,
  input  logic [rhsv_pkg::ChW-1:0] green_i,
  input  logic [rhsv_pkg::ChW-1:0] blue_i,
  output logic                   valid_o,
  input  logic                   take_i,
  output rhsv_pkg::item_t        item_o
);

  logic                 valid_q;
  rhsv_pkg::item_t      item_q, item_d;
  logic [7:0]           mx, mn, d;
  logic                 bmax, gmax;
  logic signed [11:0]   r_s, g_s, b_s, d_s, n_s;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d = mx - mn;
    bmax = (blue_i == mx);
    gmax = !bmax && (green_i == mx);
    r_s = $signed({4'b0, red_i});
    g_s = $signed({4'b0, green_i});
    b_s = $signed({4'b0, blue_i});
    d_s = $signed({4'b0, d});
    if (bmax) begin
      n_s = (d_s <<< 2) + r_s - g_s;
    end else if (gmax) begin
      n_s = (d_s <<< 1) + b_s - r_s;
    end else begin
      n_s = g_s - b_s;
      // wrap negative red sector into range
      if (n_s < 0) n_s = n_s + (d_s <<< 2) + (d_s <<< 1);
    end
    item_d.mx       = mx;
    item_d.d        = d;
    item_d.n        = n_s[rhsv_pkg::SecW-1:0];
    item_d.hue_zero = (d == 8'd0);
    item_d.sat_zero = (mx == 8'd0);
  end

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

### rtl/rhsv_fifo.sv
module rhsv_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rhsv_pkg::item_t    item_i,
  input  logic               pop_i,
  output rhsv_pkg::item_t    item_o,
  output rhsv_pkg::fifo_st_t st_o
);

  rhsv_pkg::item_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;

  assign st_o.full  = (cnt_q == 2'd2);
  assign st_o.empty = (cnt_q == 2'd0);
  assign item_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

### rtl/rhsv_div.sv
// restoring divider, one quotient bit per stage; num >> QW must be below den
module rhsv_div #(
  parameter int unsigned QW = 17,
  parameter int unsigned NW = 28,
  parameter int unsigned DW = 11
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [QW-1:0][DW-1:0] rem_q;
  logic [QW-1:0][DW-1:0] den_q;
  logic [QW-1:0][QW-1:0] low_q;
  logic [QW-1:0][QW-1:0] quo_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [QW-1:0] low_in, quo_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = DW'(num_i >> QW);
      assign den_in = den_i;
      assign low_in = num_i[QW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        den_q[k] <= den_in;
        low_q[k] <= low_in << 1;
        quo_q[k] <= {quo_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

### rtl/rhsv_back.sv
module rhsv_back #(
  parameter int unsigned FracBits = rhsv_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rhsv_pkg::fifo_st_t             st_i,
  input  rhsv_pkg::item_t                item_i,
  output logic                           pop_o,
  input  logic [rhsv_pkg::ModeW-1:0]     mode_i,
  input  logic signed [rhsv_pkg::AmtW-1:0] amount_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [FracBits:0]              hue_o,
  output logic [FracBits:0]              sat_o,
  output logic [FracBits:0]              val_o
);

  localparam int unsigned OW = FracBits + 1;
  localparam int unsigned QW = OW;
  localparam int unsigned DW = rhsv_pkg::SecW;
  localparam int unsigned NW = FracBits + DW + 1;
  localparam int unsigned PW = OW + 1 + rhsv_pkg::AmtW;
  localparam int unsigned SW = ((OW + 1 > rhsv_pkg::AmtW) ? OW + 1 : rhsv_pkg::AmtW) + 1;
  localparam logic [OW-1:0] One = OW'(1) << FracBits;

  typedef logic [255:0][OW-1:0] vtab_t;

  // value is round(mx / 255) in fixed point, one entry per channel level
  function automatic vtab_t vtab_init();
    vtab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = OW'(((longint'(i) << FracBits) + 127) / 255);
    end
    return t;
  endfunction

  localparam vtab_t VTab = vtab_init();

  logic          en;
  logic [NW-1:0] h_num, s_num;
  logic [DW-1:0] h_den, s_den;
  logic [QW-1:0] h_quo, s_quo, v_quo;
  logic [QW-1:0] vld_q, hz_q, sz_q;
  logic [QW-1:0][rhsv_pkg::ChW-1:0] mx_q;
  logic [OW-1:0] h_div, s_div;

  logic                 mul_vld_q;
  logic [OW-1:0]        h_q, s_q, v_q, mul_a;
  logic signed [PW-1:0] prod_q;

  logic                 out_vld_q;
  logic [OW-1:0]        hue_q, sat_q, val_q;
  logic [OW-1:0]        hue_d, sat_d, val_d, gain_res;
  logic signed [PW-1:0] prod_rnd;
  logic signed [SW-1:0] hsum;

  assign en    = !out_vld_q || ready_i;
  assign pop_o = en && !st_i.empty;

  always_comb begin
    h_num = (NW'(item_i.n) << FracBits) + NW'({item_i.d, 1'b0}) + NW'(item_i.d);
    s_num = (NW'(item_i.d) << FracBits) + NW'(item_i.mx >> 1);
    h_den = (DW'(item_i.d) << 2) + (DW'(item_i.d) << 1);
    s_den = DW'(item_i.mx);
  end

  rhsv_div #(.QW(QW), .NW(NW), .DW(DW)) u_div_h (
    .clk_i, .en_i(en), .num_i(h_num), .den_i(h_den), .quo_o(h_quo)
  );
  rhsv_div #(.QW(QW), .NW(NW), .DW(DW)) u_div_s (
    .clk_i, .en_i(en), .num_i(s_num), .den_i(s_den), .quo_o(s_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[QW-2:0], !st_i.empty};
      mul_vld_q <= vld_q[QW-1];
      out_vld_q <= mul_vld_q;
    end
  end

  assign v_quo = VTab[mx_q[QW-1]];
  assign h_div = hz_q[QW-1] ? '0 : h_quo;
  assign s_div = sz_q[QW-1] ? '0 : s_quo;
  assign mul_a = (mode_i == rhsv_pkg::MODE_SAT) ? s_div : v_quo;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hz_q   <= {hz_q[QW-2:0], item_i.hue_zero};
      sz_q   <= {sz_q[QW-2:0], item_i.sat_zero};
      mx_q   <= {mx_q[QW-2:0], item_i.mx};
      h_q    <= h_div;
      s_q    <= s_div;
      v_q    <= v_quo;
      prod_q <= PW'($signed({1'b0, mul_a}) * amount_i);
    end
  end

  always_comb begin
    prod_rnd = (prod_q + (PW'(1) <<< (FracBits - 1))) >>> FracBits;
    if (prod_q <= 0) gain_res = '0;
    else if (prod_rnd > $signed(PW'(One))) gain_res = One;
    else gain_res = prod_rnd[OW-1:0];

    hsum = $signed(SW'(h_q)) + SW'(amount_i);
    hue_d = h_q;
    sat_d = s_q;
    val_d = v_q;
    case (mode_i)
      rhsv_pkg::MODE_HUE: begin
        if (hsum < 0) hue_d = '0;
        else if (hsum > $signed(SW'(One))) hue_d = One;
        else hue_d = hsum[OW-1:0];
      end
      rhsv_pkg::MODE_SAT: sat_d = gain_res;
      rhsv_pkg::MODE_VAL: val_d = gain_res;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= val_d;
    end
  end

  assign valid_o = out_vld_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign val_o   = val_q;

endmodule

### rtl/rgb_to_hsv_adjust.sv
// throughput: one pixel word per cycle, sustained while the output side is ready
// path from input accept to output valid: front register, queue, the hue and saturation
// restoring dividers (one quotient bit per stage, FRAC_BITS + 1 stages), gain multiply
// register and output register
// reset: asynchronous active low, clears valids, queue pointers and config registers (mode 0, amount 0)
`include "assert_macros.svh"

module rgb_to_hsv_adjust #(
  parameter int unsigned FRAC_BITS = rhsv_pkg::FracBitsDef,
  localparam int unsigned OW  = FRAC_BITS + 1,
  localparam int unsigned OTW = ((3 * OW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // red, green, blue
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OTW-1:0]                m_axis_tdata,   // hue, saturation, brightness
  input  logic                          cfg_we_i,
  input  logic [rhsv_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [rhsv_pkg::AmtW-1:0]     cfg_wdata_i
);

  localparam logic [OW-1:0] One = OW'(1) << FRAC_BITS;

  logic [rhsv_pkg::ModeW-1:0]      mode_q;
  logic signed [rhsv_pkg::AmtW-1:0] amount_q;
  logic                            front_vld, push, pop;
  rhsv_pkg::item_t                 front_item, head_item;
  rhsv_pkg::fifo_st_t              fifo_st;
  logic [OW-1:0]                   hue, sat, val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rhsv_pkg::MODE_HUE;
      amount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rhsv_pkg::REG_MODE:   mode_q   <= cfg_wdata_i[rhsv_pkg::ModeW-1:0];
        rhsv_pkg::REG_AMOUNT: amount_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  rhsv_front u_front (
    .clk_i, .rst_ni,
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (front_vld),
    .take_i  (!fifo_st.full),
    .item_o  (front_item)
  );

  assign push = front_vld && !fifo_st.full;

  rhsv_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (head_item),
    .st_o   (fifo_st)
  );

  rhsv_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .st_i     (fifo_st),
    .item_i   (head_item),
    .pop_o    (pop),
    .mode_i   (mode_q),
    .amount_i (amount_q),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .hue_o    (hue),
    .sat_o    (sat),
    .val_o    (val)
  );

  assign m_axis_tdata = OTW'({val, sat, hue});

  `ASSERT_IMP(a_no_pop_empty, pop, !fifo_st.empty)
  `ASSERT_IMP(a_stall_front, !s_axis_tready, front_vld && fifo_st.full)
  `ASSERT_IMP(a_out_range, m_axis_tvalid, (hue <= One) && (sat <= One))
  `ASSERT_NXT(a_full_holds, fifo_st.full && !pop, fifo_st.full)

endmodule
